// File: rtl/source_text_tokenizer_macros.svh
// Assertion macros shared by the tokenizer RTL.
// Depends on a clock named clk and a synchronous reset named rst in scope.
`ifndef SOURCE_TEXT_TOKENIZER_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define STT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define STT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/stt_pkg.sv
// Shared types, codes, keyword table and byte classifiers for the tokenizer.
// No dependencies.
package stt_pkg;

  localparam int NUM_KW  = 5;
  localparam int KW_CHARS = 5;
  localparam int MAX_RES = 3;

  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_ATTR = 2'd1;
  localparam logic [1:0] MODE_NAME = 2'd2;
  localparam logic [1:0] MODE_NUM  = 2'd3;

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_EOF  = 2'd2;

  localparam logic [2:0] TYPE_ATTR = 3'd0;
  localparam logic [2:0] TYPE_ID   = 3'd1;
  localparam logic [2:0] TYPE_KW   = 3'd2;
  localparam logic [2:0] TYPE_NUM  = 3'd3;
  localparam logic [2:0] TYPE_SYM  = 3'd4;
  localparam logic [2:0] TYPE_EOF  = 3'd5;

  localparam logic [2:0] LEN_MAX = 3'd7;

  localparam logic [7:0] KW_TEXT [NUM_KW][KW_CHARS] = '{
    '{"v", "a", "r", 8'd0, 8'd0},
    '{"l", "e", "t", 8'd0, 8'd0},
    '{"f", "u", "n", "c", 8'd0},
    '{"i", "f", 8'd0, 8'd0, 8'd0},
    '{"w", "h", "i", "l", "e"}
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd3, 3'd3, 3'd4, 3'd2, 3'd5};

  typedef struct packed {
    logic [1:0] mode;
    logic [4:0] cand;
    logic [2:0] len;
  } tok_state_t;

  typedef struct packed {
    logic       first;
    logic [7:0] byte_val;
    logic [2:0] ttype;
    logic [1:0] kind;
  } result_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_symbol(input logic [7:0] c);
    return c == "=" || c == ":" || c == "+" || c == "-" ||
           c == "(" || c == ")" || c == "{" || c == "}";
  endfunction

  // Keep only the keywords whose character at the current length matches.
  function automatic logic [4:0] name_take(input logic [4:0] cand,
                                           input logic [2:0] len,
                                           input logic [7:0] c);
    logic [4:0] mask;
    mask = '0;
    for (int k = 0; k < NUM_KW; k++) begin
      if (cand[k] && len < KW_LEN[k]) begin
        if (KW_TEXT[k][len] == c) begin
          mask[k] = 1'b1;
        end
      end
    end
    return mask;
  endfunction

endpackage

// File: rtl/source_text_tokenizer.sv
// Streaming source-text tokenizer, top level.
// Depends on stt_pkg, stt_step and source_text_tokenizer_macros.svh.
//
// Input stream: one request per source byte. s_tuser is the op (0 byte,
// 1 end of source), s_tdata the byte. Output stream: one item per beat,
// tdata the token byte, tuser {first_of_token, token_type, item_kind},
// tlast marks the final item caused by one request.
// A request sits in a two-entry input buffer, is classified combinationally and
// its results (zero to three) land in a burst register that drives the output.
// The input buffer entry and the burst register lie between accept and first
// result. One request per cycle while each gives at most one result and the
// receiver does not stall; a request with more results holds the burst
// register until its last is taken, which limits the rate. s_tready depends
// on registers only. Reset clears the open token, the keyword match state, the
// input buffer and the burst register. When the receiver stalls, the current
// item holds and the input buffer fills, after which s_tready drops.
`include "source_text_tokenizer_macros.svh"

module source_text_tokenizer import stt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_code
  input  logic       s_tuser,   // [0] op
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] byte_out
  output logic [5:0] m_tuser,   // [1:0] item_kind, [4:2] token_type, [5] first_of_token
  output logic       m_tlast    // last_result
);

  // Two-entry input buffer
  logic       a_valid, b_valid;
  logic       a_op, b_op;
  logic [7:0] a_char, b_char;

  // Burst register
  logic          bv;
  logic [1:0]    bcnt;
  logic [1:0]    bidx;
  result_t [2:0] bres;

  tok_state_t    tstate;
  tok_state_t    tstate_next;
  result_t [2:0] step_res;
  logic [1:0]    step_cnt;

  logic push, load, burst_last, out_fire;

  assign s_tready   = !b_valid;
  assign push       = s_tvalid && s_tready;
  assign burst_last = (bidx == bcnt - 2'd1);
  assign out_fire   = m_tvalid && m_tready;
  assign load       = a_valid && (!bv || (out_fire && burst_last));

  stt_step u_step (
    .op        (a_op),
    .char_code (a_char),
    .cur       (tstate),
    .nxt       (tstate_next),
    .results   (step_res),
    .res_count (step_cnt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (load) begin
      if (b_valid) begin
        a_op    <= b_op;
        a_char  <= b_char;
        b_valid <= 1'b0;
      end else if (push) begin
        a_op   <= s_tuser;
        a_char <= s_tdata;
      end else begin
        a_valid <= 1'b0;
      end
    end else if (push) begin
      if (!a_valid) begin
        a_valid <= 1'b1;
        a_op    <= s_tuser;
        a_char  <= s_tdata;
      end else begin
        b_valid <= 1'b1;
        b_op    <= s_tuser;
        b_char  <= s_tdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tstate <= '0;
      bv     <= 1'b0;
      bcnt   <= 2'd0;
      bidx   <= 2'd0;
    end else if (load) begin
      tstate <= tstate_next;
      // A dropped byte with nothing open leaves the burst register empty.
      bv     <= (step_cnt != 2'd0);
      bcnt   <= step_cnt;
      bidx   <= 2'd0;
      bres   <= step_res;
    end else if (out_fire) begin
      if (burst_last) begin
        bv <= 1'b0;
      end else begin
        bidx <= bidx + 2'd1;
      end
    end
  end

  assign m_tvalid = bv;
  assign m_tdata  = bres[bidx].byte_val;
  assign m_tuser  = {bres[bidx].first, bres[bidx].ttype, bres[bidx].kind};
  assign m_tlast  = burst_last;

  `STT_ASSERT_NOW(a_idx_in_burst, m_tvalid, bidx < bcnt, "burst index past count")
  `STT_ASSERT_NOW(a_spare_needs_main, b_valid, a_valid, "spare entry without main entry")
  `STT_ASSERT_NOW(a_eof_is_last, m_tvalid && m_tuser[1:0] == KIND_EOF, m_tlast,
                  "eof item not last of its request")
  `STT_ASSERT_NEXT(a_eof_resets, load && a_op == OP_END, tstate == '0,
                   "token state not cleared after end of source")

endmodule

// File: rtl/stt_step.sv
// One tokenizer step: classify a byte against the open token and list its results.
// Depends on stt_pkg.
module stt_step import stt_pkg::*; (
  input  logic             op,
  input  logic [7:0]       char_code,
  input  tok_state_t       cur,
  output tok_state_t       nxt,
  output result_t [2:0]    results,
  output logic [1:0]       res_count
);

  logic       cont;
  logic       kw_hit;
  logic [2:0] open_type;
  logic [4:0] take_cont;
  logic [4:0] take_new;

  always_comb begin
    kw_hit = 1'b0;
    for (int k = 0; k < NUM_KW; k++) begin
      if (cur.cand[k] && cur.len == KW_LEN[k]) begin
        kw_hit = 1'b1;
      end
    end
    case (cur.mode)
      MODE_ATTR: open_type = TYPE_ATTR;
      MODE_NUM:  open_type = TYPE_NUM;
      default:   open_type = kw_hit ? TYPE_KW : TYPE_ID;
    endcase
  end

  assign take_cont = name_take(cur.cand, cur.len, char_code);
  assign take_new  = name_take({NUM_KW{1'b1}}, 3'd0, char_code);

  always_comb begin
    case (cur.mode)
      MODE_ATTR, MODE_NAME: cont = is_alpha(char_code) || is_digit(char_code) ||
                                   char_code == "_";
      MODE_NUM:             cont = is_alpha(char_code) || is_digit(char_code) ||
                                   char_code == ".";
      default:              cont = 1'b0;
    endcase
  end

  always_comb begin
    results   = '0;
    res_count = 2'd0;
    nxt       = cur;
    if (op == OP_END) begin
      if (cur.mode != MODE_NONE) begin
        results[res_count] = '{first: 1'b0, byte_val: 8'd0, ttype: open_type,
                               kind: KIND_END};
        res_count = res_count + 2'd1;
      end
      results[res_count] = '{first: 1'b0, byte_val: 8'd0, ttype: TYPE_EOF,
                             kind: KIND_EOF};
      res_count = res_count + 2'd1;
      nxt = '0;
    end else if (cont) begin
      if (cur.mode == MODE_NAME) begin
        nxt.cand = take_cont;
        nxt.len  = (cur.len < LEN_MAX) ? cur.len + 3'd1 : cur.len;
        results[0] = '{first: 1'b0, byte_val: char_code, ttype: TYPE_ID,
                       kind: KIND_CHAR};
      end else begin
        results[0] = '{first: 1'b0, byte_val: char_code, ttype: open_type,
                       kind: KIND_CHAR};
      end
      res_count = 2'd1;
    end else begin
      // Close the open token before starting whatever this byte begins.
      if (cur.mode != MODE_NONE) begin
        results[0] = '{first: 1'b0, byte_val: 8'd0, ttype: open_type,
                       kind: KIND_END};
        res_count = 2'd1;
        nxt = '0;
      end
      if (char_code == ".") begin
        nxt.mode = MODE_ATTR;
        results[res_count] = '{first: 1'b1, byte_val: char_code, ttype: TYPE_ATTR,
                               kind: KIND_CHAR};
        res_count = res_count + 2'd1;
      end else if (is_alpha(char_code) || char_code == "_") begin
        nxt.mode = MODE_NAME;
        nxt.cand = take_new;
        nxt.len  = 3'd1;
        results[res_count] = '{first: 1'b1, byte_val: char_code, ttype: TYPE_ID,
                               kind: KIND_CHAR};
        res_count = res_count + 2'd1;
      end else if (is_digit(char_code)) begin
        nxt.mode = MODE_NUM;
        results[res_count] = '{first: 1'b1, byte_val: char_code, ttype: TYPE_NUM,
                               kind: KIND_CHAR};
        res_count = res_count + 2'd1;
      end else if (is_symbol(char_code)) begin
        results[res_count] = '{first: 1'b1, byte_val: char_code, ttype: TYPE_SYM,
                               kind: KIND_CHAR};
        res_count = res_count + 2'd1;
        results[res_count] = '{first: 1'b0, byte_val: 8'd0, ttype: TYPE_SYM,
                               kind: KIND_END};
        res_count = res_count + 2'd1;
      end
    end
  end

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for source_text_tokenizer: streams source bytes and end
// markers, predicts token items from a behavioral tokenizer, and checks each result.
// Depends on stt_pkg and the source_text_tokenizer RTL.
module tb_top;
  import stt_pkg::*;

  typedef enum logic [2:0] {
    CLS_OTHER, CLS_DOT, CLS_LETTER, CLS_UNDERSCORE, CLS_DIGIT, CLS_SYMBOL
  } byte_class_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] ttype;
    logic [7:0] byte_val;
    logic       first;
    logic       last;
  } token_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tuser = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [5:0] m_tuser;
  logic       m_tlast;

  // Predictor state: the open token and the keyword match progress
  logic [1:0] open_mode = MODE_NONE;
  logic [4:0] kw_live = '0;
  logic [2:0] name_len = '0;

  token_item_t pending_tokens[$];
  int          mismatch_count = 0;
  int          requests_sent = 0;
  int          sink_hold = 0;
  bit          src_idle_on = 1'b0;
  bit          sink_stall_on = 1'b0;

  source_text_tokenizer DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #4800000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic byte_class_t classify_byte(input logic [7:0] c);
    if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) return CLS_LETTER;
    if (c >= "0" && c <= "9") return CLS_DIGIT;
    case (c)
      ".": return CLS_DOT;
      "_": return CLS_UNDERSCORE;
      "=", ":", "+", "-", "(", ")", "{", "}": return CLS_SYMBOL;
      default: return CLS_OTHER;
    endcase
  endfunction

  function automatic logic [2:0] closing_type();
    if (open_mode == MODE_ATTR) return TYPE_ATTR;
    if (open_mode == MODE_NUM) return TYPE_NUM;
    for (int k = 0; k < NUM_KW; k++) begin
      if (kw_live[k] && KW_LEN[k] == name_len) return TYPE_KW;
    end
    return TYPE_ID;
  endfunction

  // Narrow the keyword candidates by one more name byte; length saturates.
  function automatic void match_keyword_char(input logic [7:0] c);
    logic [4:0] still;
    still = '0;
    for (int k = 0; k < NUM_KW; k++) begin
      if (kw_live[k] && name_len < KW_LEN[k]) begin
        if (KW_TEXT[k][name_len] == c) still[k] = 1'b1;
      end
    end
    kw_live = still;
    if (name_len != LEN_MAX) name_len = name_len + 3'd1;
  endfunction

  function automatic void push_token(input logic [1:0] kind, input logic [2:0] ttype,
                                     input logic [7:0] b, input logic first);
    token_item_t item;
    item.kind = kind;
    item.ttype = ttype;
    item.byte_val = b;
    item.first = first;
    item.last = 1'b0;
    pending_tokens.insert(pending_tokens.size(), item);
  endfunction

  function automatic void predict_tokens(input logic op, input logic [7:0] c);
    byte_class_t cls;
    logic        extend;
    int          prior;
    token_item_t tail;
    prior = pending_tokens.size();
    cls = classify_byte(c);
    extend = 1'b0;
    if (op == OP_END) begin
      if (open_mode != MODE_NONE) push_token(KIND_END, closing_type(), 8'h00, 1'b0);
      push_token(KIND_EOF, TYPE_EOF, 8'h00, 1'b0);
      open_mode = MODE_NONE;
      kw_live = '0;
      name_len = '0;
    end else begin
      if (open_mode == MODE_ATTR || open_mode == MODE_NAME) begin
        extend = cls == CLS_LETTER || cls == CLS_UNDERSCORE || cls == CLS_DIGIT;
      end else if (open_mode == MODE_NUM) begin
        extend = cls == CLS_LETTER || cls == CLS_DIGIT || cls == CLS_DOT;
      end
      if (extend) begin
        if (open_mode == MODE_NAME) begin
          match_keyword_char(c);
          push_token(KIND_CHAR, TYPE_ID, c, 1'b0);
        end else begin
          push_token(KIND_CHAR, closing_type(), c, 1'b0);
        end
      end else begin
        if (open_mode != MODE_NONE) begin
          push_token(KIND_END, closing_type(), 8'h00, 1'b0);
          open_mode = MODE_NONE;
          kw_live = '0;
          name_len = '0;
        end
        case (cls)
          CLS_DOT: begin
            open_mode = MODE_ATTR;
            push_token(KIND_CHAR, TYPE_ATTR, c, 1'b1);
          end
          CLS_LETTER, CLS_UNDERSCORE: begin
            open_mode = MODE_NAME;
            kw_live = '1;
            name_len = '0;
            match_keyword_char(c);
            push_token(KIND_CHAR, TYPE_ID, c, 1'b1);
          end
          CLS_DIGIT: begin
            open_mode = MODE_NUM;
            push_token(KIND_CHAR, TYPE_NUM, c, 1'b1);
          end
          CLS_SYMBOL: begin
            push_token(KIND_CHAR, TYPE_SYM, c, 1'b1);
            push_token(KIND_END, TYPE_SYM, 8'h00, 1'b0);
          end
          default: ;
        endcase
      end
    end
    // Flag the final result of this request
    if (pending_tokens.size() > prior) begin
      tail = pending_tokens[pending_tokens.size() - 1];
      tail.last = 1'b1;
      pending_tokens[pending_tokens.size() - 1] = tail;
    end
  endfunction

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // Sink side: random stalls, some long
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      m_tready <= 1'b0;
      sink_hold = sink_hold - 1;
    end else if (sink_stall_on && $urandom_range(0, 99) < 30) begin
      m_tready <= 1'b0;
      sink_hold = idle_length();
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    token_item_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_tokens.size() == 0) begin
        $error("result with nothing expected: tuser %h tdata %h tlast %b",
               m_tuser, m_tdata, m_tlast);
        mismatch_count++;
      end else begin
        want = pending_tokens.pop_front();
        check_field("item_kind", int'(want.kind), int'(m_tuser[1:0]));
        check_field("token_type", int'(want.ttype), int'(m_tuser[4:2]));
        check_field("first_of_token", int'(want.first), int'(m_tuser[5]));
        check_field("byte_out", int'(want.byte_val), int'(m_tdata));
        check_field("last_result", int'(want.last), int'(m_tlast));
      end
    end
  end

  // Called at a falling edge; returns at a falling edge with tvalid still high.
  task automatic send_request(input logic op, input logic [7:0] c);
    int gap;
    gap = src_idle_on ? idle_length() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_tokens(op, c);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic send_char(input logic [7:0] c);
    send_request(OP_CHAR, c);
  endtask

  task automatic send_end();
    // Byte field is ignored on an end marker; keep it busy anyway
    send_request(OP_END, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  function automatic logic [7:0] rand_name_char();
    int r;
    r = $urandom_range(0, 63);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + (r - 26));
    if (r < 62) return 8'("0" + (r - 52));
    return "_";
  endfunction

  function automatic logic [7:0] rand_symbol();
    case ($urandom_range(0, 7))
      0: return "=";
      1: return ":";
      2: return "+";
      3: return "-";
      4: return "(";
      5: return ")";
      6: return "{";
      default: return "}";
    endcase
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 6))
      0: return " ";
      1: return 8'h09;
      2: return 8'h0A;
      3: return 8'h0B;
      4: return 8'h0C;
      5: return 8'h0D;
      default: return 8'($urandom_range(128, 255));
    endcase
  endfunction

  task automatic send_identifier();
    int n;
    logic [7:0] c;
    n = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
    c = rand_name_char();
    // First byte must start a name: turn a digit into '_'
    if (classify_byte(c) == CLS_DIGIT) c = "_";
    send_char(c);
    for (int i = 1; i < n; i++) send_char(rand_name_char());
  endtask

  // A keyword spelled exactly, cut short, run on, or with one byte changed.
  task automatic send_keyword_variant();
    int k;
    int n;
    int variant;
    int pos;
    logic [7:0] c;
    k = $urandom_range(0, NUM_KW - 1);
    variant = $urandom_range(0, 3);
    n = int'(KW_LEN[k]);
    if (variant == 1) n = $urandom_range(1, KW_LEN[k] - 1);
    pos = $urandom_range(0, KW_LEN[k] - 1);
    for (int i = 0; i < n; i++) begin
      c = KW_TEXT[k][i];
      if (variant == 3 && i == pos) c = ($urandom_range(0, 1) == 0) ? (c ^ 8'h20) : rand_name_char();
      send_char(c);
    end
    if (variant == 2) begin
      repeat ($urandom_range(1, 4)) send_char(rand_name_char());
    end
  endtask

  task automatic send_number();
    int r;
    send_char(8'("0" + $urandom_range(0, 9)));
    repeat ($urandom_range(0, 4)) begin
      r = $urandom_range(0, 9);
      if (r < 5) send_char(8'("0" + $urandom_range(0, 9)));
      else if (r < 7) send_char(".");
      else send_char(8'("a" + $urandom_range(0, 25)));
    end
  endtask

  task automatic send_attribute();
    send_char(".");
    repeat ($urandom_range(0, 4)) send_char(rand_name_char());
  endtask

  task automatic toggle_idling();
    if ($urandom_range(0, 15) == 0) src_idle_on = ~src_idle_on;
    if ($urandom_range(0, 15) == 0) sink_stall_on = ~sink_stall_on;
  endtask

  task automatic test_directed_tokens();
    send_text("while");
    send_char(8'h09);
    send_text(".a_9 7.Z=");
    send_char(8'hFF);
    send_char("_");
    send_end();
    send_end();
    send_char(8'h00);
    send_text("if");
    send_end();
  endtask

  task automatic test_keyword_matching();
    int stop_at;
    stop_at = requests_sent + 60;
    src_idle_on = 1'b1;
    sink_stall_on = 1'b1;
    while (requests_sent < stop_at) begin
      if ($urandom_range(0, 2) == 0) send_identifier();
      else send_keyword_variant();
      case ($urandom_range(0, 5))
        0: send_end();
        1: send_char(rand_symbol());
        default: send_char(rand_blank());
      endcase
      toggle_idling();
    end
  endtask

  task automatic test_mixed_stream();
    int stop_at;
    int r;
    stop_at = requests_sent + 120;
    while (requests_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 18) send_keyword_variant();
      else if (r < 33) send_identifier();
      else if (r < 48) send_number();
      else if (r < 58) send_attribute();
      else if (r < 70) send_char(rand_symbol());
      else if (r < 82) send_char(rand_blank());
      else if (r < 95) send_char(8'($urandom_range(0, 255)));
      else send_end();
      // Leave tokens back to back half the time
      if ($urandom_range(0, 1) == 0) send_char(rand_blank());
      toggle_idling();
    end
    send_end();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_tokens();
    test_keyword_matching();
    test_mixed_stream();
    s_tvalid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
